// File: rtl/core/irsa_pkg.sv
// Package for the image rotation scatter address block.
// Holds register indexes, rotation codes, limits and the controller command type.
// Has no dependencies.
package irsa_pkg;

    localparam int unsigned MAX_DIM = 4096;

    localparam int unsigned CFG_W   = 13;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned ROT_W   = 2;
    localparam int unsigned BPP_W   = 5;
    localparam int unsigned PROD_W  = POS_W + DIM_W;
    localparam int unsigned ADDR_W  = 28;

    localparam logic [IDX_W-1:0] REG_SRC_WIDTH       = 2'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT      = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROTATION        = 2'd2;
    localparam logic [IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd3;

    localparam logic [ROT_W-1:0] ROT_INVALID = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90      = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180     = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270     = 2'd3;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_RST = 13'd1;
    localparam logic [BPP_W-1:0] BPP_MAX = 5'd16;
    localparam logic [BPP_W-1:0] BPP_RST = 5'd4;

    typedef struct packed {
        logic accept;
        logic map_en;
        logic out_load;
    } t_dp_cmd;

endpackage

// File: rtl/core/irsa_ctrl.sv
// Controller state machine for the image rotation scatter address block.
// Sequences accept, mapping and address scaling; owns the output valid flag.
// Depends on irsa_pkg.
module irsa_ctrl
    import irsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAP   = 2'd1;
    localparam logic [1:0] S_SCALE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_dp_cmd    cmd;

    always_comb begin
        n_state      = r_state;
        cmd.accept   = 1'b0;
        cmd.map_en   = 1'b0;
        cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_MAP;
                end
            end
            S_MAP: begin
                cmd.map_en = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: rtl/core/irsa_datapath.sv
// Datapath for the image rotation scatter address block.
// Holds configuration, source counters, the rotation mapping and the address multipliers.
// Depends on irsa_pkg.
module irsa_datapath
    import irsa_pkg::*;
#(
    parameter int unsigned PIXEL_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  t_dp_cmd               i_cmd,
    input  logic [PIXEL_BITS-1:0] i_pixel_in,
    input  logic                  i_frame_start,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic [POS_W-1:0]      o_dest_col,
    output logic [POS_W-1:0]      o_dest_row,
    output logic [ADDR_W-1:0]     o_byte_address,
    output logic                  o_frame_last,
    output logic                  o_bad_rotation
);

    logic [DIM_W-1:0] r_src_width;
    logic [DIM_W-1:0] r_src_height;
    logic [ROT_W-1:0] r_rotation;
    logic [BPP_W-1:0] r_bpp;

    logic [POS_W-1:0] r_col_count;
    logic [POS_W-1:0] r_row_count;

    logic [PIXEL_BITS-1:0] r_pix;
    logic [POS_W-1:0]      r_c;
    logic [POS_W-1:0]      r_r;
    logic                  r_last;
    logic                  r_bad;

    logic [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]  r_dc;
    logic [POS_W-1:0]  r_dr;

    logic [PIXEL_BITS-1:0] r_pixel_out;
    logic [POS_W-1:0]      r_dest_col;
    logic [POS_W-1:0]      r_dest_row;
    logic [ADDR_W-1:0]     r_byte_address;
    logic                  r_frame_last;
    logic                  r_bad_rotation;

    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [POS_W-1:0] w_m1;
    logic [POS_W-1:0] h_m1;
    logic [BPP_W-1:0] bpp;
    logic             restart;
    logic [POS_W-1:0] c;
    logic [POS_W-1:0] r;
    logic             col_end;
    logic             row_end;
    logic [POS_W-1:0] dc;
    logic [POS_W-1:0] dr;
    logic [DIM_W-1:0] dw;
    logic [PROD_W-1:0] sum;
    logic [PROD_W+BPP_W-1:0] scaled;

    always_comb begin
        w = r_src_width;
        if (r_src_width == '0) begin
            w = DIM_W'(1);
        end else if (r_src_width > DIM_MAX) begin
            w = DIM_MAX;
        end
        h = r_src_height;
        if (r_src_height == '0) begin
            h = DIM_W'(1);
        end else if (r_src_height > DIM_MAX) begin
            h = DIM_MAX;
        end
        bpp = r_bpp;
        if (r_bpp == '0) begin
            bpp = BPP_W'(1);
        end else if (r_bpp > BPP_MAX) begin
            bpp = BPP_MAX;
        end
    end

    assign w_m1 = POS_W'(w - DIM_W'(1));
    assign h_m1 = POS_W'(h - DIM_W'(1));

    assign restart = i_frame_start || ({1'b0, r_col_count} >= w)
                     || ({1'b0, r_row_count} >= h);
    assign c       = restart ? '0 : r_col_count;
    assign r       = restart ? '0 : r_row_count;
    assign col_end = (c == w_m1);
    assign row_end = (r == h_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_RST;
            r_src_height <= DIM_RST;
            r_rotation   <= ROT_90;
            r_bpp        <= BPP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SRC_WIDTH:       r_src_width  <= i_cfg_wdata;
                REG_SRC_HEIGHT:      r_src_height <= i_cfg_wdata;
                REG_ROTATION:        r_rotation   <= i_cfg_wdata[ROT_W-1:0];
                REG_BYTES_PER_PIXEL: r_bpp        <= i_cfg_wdata[BPP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (i_cmd.accept) begin
            if (col_end) begin
                r_col_count <= '0;
                r_row_count <= row_end ? '0 : r + POS_W'(1);
            end else begin
                r_col_count <= c + POS_W'(1);
                r_row_count <= r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix  <= i_pixel_in;
            r_c    <= c;
            r_r    <= r;
            r_last <= col_end && row_end;
            r_bad  <= (r_rotation == ROT_INVALID);
        end
    end

    always_comb begin
        dc = '0;
        dr = '0;
        dw = '0;
        unique case (r_rotation)
            ROT_90: begin
                dw = h;
                dr = r_c;
                dc = h_m1 - r_r;
            end
            ROT_180: begin
                dw = w;
                dr = h_m1 - r_r;
                dc = w_m1 - r_c;
            end
            ROT_270: begin
                dw = h;
                dr = w_m1 - r_c;
                dc = r_r;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_en) begin
            r_prod <= PROD_W'(dr) * PROD_W'(dw);
            r_dc   <= dc;
            r_dr   <= dr;
        end
    end

    assign sum    = r_prod + PROD_W'(r_dc);
    assign scaled = sum * bpp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pixel_out    <= r_pix;
            r_dest_col     <= r_dc;
            r_dest_row     <= r_dr;
            r_byte_address <= r_bad ? '0 : scaled[ADDR_W-1:0];
            r_frame_last   <= r_last;
            r_bad_rotation <= r_bad;
        end
    end

    assign o_pixel_out    = r_pixel_out;
    assign o_dest_col     = r_dest_col;
    assign o_dest_row     = r_dest_row;
    assign o_byte_address = r_byte_address;
    assign o_frame_last   = r_frame_last;
    assign o_bad_rotation = r_bad_rotation;

endmodule

// File: rtl/core/image_rotate_scatter_address.sv
// Top level of the image rotation scatter address block.
// Joins the controller and the datapath; depends on irsa_pkg, irsa_ctrl and irsa_datapath.
//
// Each source word is accepted in the idle state, which steps the source counters; the
// map state does the rotation mapping and the row times width multiply; the scale state
// adds the column, scales by bytes per pixel and loads the output register. A new word is
// accepted while the previous result still waits in the output register, so a stall on the
// output side only holds the block once a second result is ready to load.
module image_rotate_scatter_address
    import irsa_pkg::*;
#(
    parameter int unsigned PIXEL_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIXEL_BITS-1:0] i_pixel_in,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic [POS_W-1:0]      o_dest_col,
    output logic [POS_W-1:0]      o_dest_row,
    output logic [ADDR_W-1:0]     o_byte_address,
    output logic                  o_frame_last,
    output logic                  o_bad_rotation
);

    t_dp_cmd cmd;

    irsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    irsa_datapath #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .i_pixel_in     (i_pixel_in),
        .i_frame_start  (i_frame_start),
        .o_pixel_out    (o_pixel_out),
        .o_dest_col     (o_dest_col),
        .o_dest_row     (o_dest_row),
        .o_byte_address (o_byte_address),
        .o_frame_last   (o_frame_last),
        .o_bad_rotation (o_bad_rotation)
    );

endmodule

// File: dv/tb_image_rotate_scatter_address.sv
// Self-checking testbench for image_rotate_scatter_address: streams source pixel words
// through the block under several frame settings and checks every placement it returns.
// Depends on irsa_pkg and the image_rotate_scatter_address RTL.
`timescale 1ns / 1ps

module tb_image_rotate_scatter_address;
    import irsa_pkg::*;

    typedef struct {
        logic [31:0] pixel;
        logic        frame_start;
        bit          drain;
    } t_src_word;

    typedef struct {
        logic [31:0]       pixel;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [ADDR_W-1:0] addr;
        logic              last;
        logic              bad;
    } t_placement;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [31:0]       i_pixel_in = '0;
    logic              i_frame_start = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [31:0]       o_pixel_out;
    logic [POS_W-1:0]  o_dest_col;
    logic [POS_W-1:0]  o_dest_row;
    logic [ADDR_W-1:0] o_byte_address;
    logic              o_frame_last;
    logic              o_bad_rotation;

    image_rotate_scatter_address DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_in     (i_pixel_in),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_out    (o_pixel_out),
        .o_dest_col     (o_dest_col),
        .o_dest_row     (o_dest_row),
        .o_byte_address (o_byte_address),
        .o_frame_last   (o_frame_last),
        .o_bad_rotation (o_bad_rotation)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_src_word   words_pending[$];
    t_placement  placements_due[$];

    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [ROT_W-1:0] cfg_rot;
    logic [BPP_W-1:0] cfg_bpp;
    int unsigned      col_pos;
    int unsigned      row_pos;

    int  words_offered = 0;
    int  words_taken = 0;
    int  words_queued = 0;
    int  results_seen = 0;
    int  results_noted = 0;
    int  frames_closed = 0;
    int  bad_seen = 0;
    int  settings_used = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    int  out_wait = 0;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    bit  in_idle_on = 1'b1;
    bit  out_idle_on = 1'b1;

    function automatic int unsigned fit_dim(logic [DIM_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        if (v > DIM_MAX) begin
            return MAX_DIM;
        end
        return 32'(v);
    endfunction

    // Works out where one source word lands and steps the source position.
    function automatic t_placement rotate_place(logic [31:0] px, logic fs);
        t_placement  p;
        int unsigned w, h, bpp, c, r, dw, dr, dc;
        w = fit_dim(cfg_width);
        h = fit_dim(cfg_height);
        bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > BPP_MAX) ? BPP_MAX : cfg_bpp);
        c = col_pos;
        r = row_pos;
        if (fs || c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        dw = w;
        dr = 0;
        dc = 0;
        case (cfg_rot)
            ROT_90: begin
                dw = h;
                dr = c;
                dc = h - 1 - r;
            end
            ROT_180: begin
                dr = h - 1 - r;
                dc = w - 1 - c;
            end
            ROT_270: begin
                dw = h;
                dr = w - 1 - c;
                dc = r;
            end
            default: ;
        endcase
        p.pixel = px;
        p.col = POS_W'(dc);
        p.row = POS_W'(dr);
        p.addr = ADDR_W'((dr * dw + dc) * bpp);
        p.last = (c == w - 1) && (r == h - 1);
        p.bad = (cfg_rot == ROT_INVALID);
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
        return p;
    endfunction

    task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got,
                 want);
        mismatches++;
    endtask

    // Monitor: register writes, accepted words and accepted results, all at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width = DIM_RST;
            cfg_height = DIM_RST;
            cfg_rot = ROT_90;
            cfg_bpp = BPP_RST;
            col_pos = 0;
            row_pos = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SRC_WIDTH:       cfg_width = i_cfg_wdata;
                    REG_SRC_HEIGHT:      cfg_height = i_cfg_wdata;
                    REG_ROTATION:        cfg_rot = i_cfg_wdata[ROT_W-1:0];
                    REG_BYTES_PER_PIXEL: cfg_bpp = i_cfg_wdata[BPP_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (placements_due.size() == 0) begin
                    note_mismatch("word with nothing due, pixel", o_pixel_out, 0);
                end else begin
                    t_placement want;
                    want = placements_due.pop_front();
                    if (o_pixel_out !== want.pixel)
                        note_mismatch("pixel_out", o_pixel_out, want.pixel);
                    if (o_dest_col !== want.col)
                        note_mismatch("dest_col", o_dest_col, want.col);
                    if (o_dest_row !== want.row)
                        note_mismatch("dest_row", o_dest_row, want.row);
                    if (o_byte_address !== want.addr)
                        note_mismatch("byte_address", o_byte_address, want.addr);
                    if (o_frame_last !== want.last)
                        note_mismatch("frame_last", o_frame_last, want.last);
                    if (o_bad_rotation !== want.bad)
                        note_mismatch("bad_rotation", o_bad_rotation, want.bad);
                end
                if (o_frame_last === 1'b1)
                    frames_closed++;
                if (o_bad_rotation === 1'b1)
                    bad_seen++;
                results_seen++;
            end
            if (i_in_valid && !o_in_stall) begin
                placements_due.push_back(rotate_place(i_pixel_in, i_frame_start));
                words_taken++;
            end
        end
    end

    // Driver: offers queued words at the falling edge and holds them while stalled.
    always @(negedge i_clk) begin : feed
        t_src_word wd;
        logic      nv;
        nv = i_in_valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!(i_in_valid && words_offered != words_taken)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (words_pending.size() > 0 &&
                         !(words_pending[0].drain && placements_due.size() != 0)) begin
                wd = words_pending.pop_front();
                i_pixel_in <= wd.pixel;
                i_frame_start <= wd.frame_start;
                nv = 1'b1;
                words_offered++;
                gap_left = in_idle_on ? $urandom_range(0, 12) : 0;
            end
        end
        i_in_valid <= nv;
    end

    // Receiver: stalls per result, plus a long hold-off when one is asked for.
    always @(negedge i_clk) begin : drain_out
        logic st;
        if (results_seen != results_noted) begin
            results_noted = results_seen;
            out_wait = out_idle_on ? $urandom_range(0, 12) : 0;
        end
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            st = 1'b1;
        end else if (out_wait > 0 && o_out_valid) begin
            out_wait--;
            st = 1'b1;
        end else begin
            st = 1'b0;
        end
        i_out_stall <= st;
    end

    task automatic settle();
        while (!(words_pending.size() == 0 && words_offered == words_taken &&
                 placements_due.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [ROT_W-1:0] rot, input logic [BPP_W-1:0] bpp);
        settle();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_SRC_WIDTH;
        i_cfg_wdata <= CFG_W'(w);
        @(negedge i_clk);
        i_cfg_index <= REG_SRC_HEIGHT;
        i_cfg_wdata <= CFG_W'(h);
        @(negedge i_clk);
        i_cfg_index <= REG_ROTATION;
        i_cfg_wdata <= CFG_W'(rot);
        @(negedge i_clk);
        i_cfg_index <= REG_BYTES_PER_PIXEL;
        i_cfg_wdata <= CFG_W'(bpp);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_word(logic [31:0] px, logic fs, bit drain);
        t_src_word wd;
        wd.pixel = px;
        wd.frame_start = fs;
        wd.drain = drain;
        words_pending.push_back(wd);
        words_queued++;
    endtask

    // Mostly whole frames with random pixels; the rest is broken or noisy frame marks.
    task automatic queue_random_phase();
        logic [DIM_W-1:0] w, h;
        logic [ROT_W-1:0] rot;
        logic [BPP_W-1:0] bpp;
        int               frame_px, n;
        if ($urandom_range(0, 7) == 0) begin
            w = DIM_W'($urandom_range(0, 8191));
            h = DIM_W'($urandom_range(0, 8191));
        end else begin
            w = DIM_W'($urandom_range(1, 9));
            h = DIM_W'($urandom_range(1, 9));
        end
        rot = ($urandom_range(0, 7) == 0) ? ROT_INVALID : ROT_W'($urandom_range(1, 3));
        bpp = ($urandom_range(0, 3) == 0) ? BPP_W'($urandom_range(0, 31))
                                          : BPP_W'($urandom_range(1, 16));
        write_config(w, h, rot, bpp);
        in_idle_on = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
        frame_px = fit_dim(w) * fit_dim(h);
        repeat ($urandom_range(1, 4)) begin
            if (frame_px > 120 || $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 40);
                for (int k = 0; k < n; k++)
                    queue_word($urandom(), $urandom_range(0, 7) == 0,
                               $urandom_range(0, 39) == 0);
            end else begin
                for (int k = 0; k < frame_px; k++)
                    queue_word($urandom(), k == 0 && $urandom_range(0, 5) != 0,
                               $urandom_range(0, 39) == 0);
            end
        end
    endtask

    initial begin : stimulus
        int random_base;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, then the pixel extremes.
        queue_word(32'h0000_0000, 1'b0, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        // Width above the limit, largest frame and word size: the top address.
        write_config(13'd8191, 13'd4096, ROT_180, 5'd16);
        queue_word(32'hA5A5_5A5A, 1'b1, 1'b0);
        queue_word(32'h5A5A_A5A5, 1'b0, 1'b0);
        queue_word(32'h8000_0001, 1'b0, 1'b0);
        // Zero dimensions and word size with an invalid rotation.
        write_config(13'd0, 13'd0, ROT_INVALID, 5'd0);
        queue_word(32'h1234_5678, 1'b1, 1'b0);
        queue_word(32'h9ABC_DEF0, 1'b0, 1'b0);
        // A whole small frame and one word more at 90 degrees with an oversized word size.
        write_config(13'd3, 13'd2, ROT_90, 5'd31);
        for (int k = 0; k < 7; k++)
            queue_word($urandom(), k == 0, 1'b0);
        // 270 degrees with a frame mark in the middle of a frame.
        write_config(13'd3, 13'd2, ROT_270, 5'd1);
        queue_word($urandom(), 1'b0, 1'b0);
        queue_word($urandom(), 1'b0, 1'b0);
        queue_word($urandom(), 1'b1, 1'b0);
        queue_word($urandom(), 1'b0, 1'b0);
        // The frame shrinks below the stored position.
        write_config(13'd2, 13'd1, ROT_180, 5'd5);
        queue_word($urandom(), 1'b0, 1'b0);
        queue_word($urandom(), 1'b0, 1'b0);
        queue_word($urandom(), 1'b0, 1'b0);

        // Long output hold-off while words keep coming, then a pause until all are out.
        write_config(13'd5, 13'd4, ROT_90, 5'd2);
        in_idle_on = 1'b0;
        hold_asked++;
        for (int k = 0; k < 60; k++)
            queue_word($urandom(), k % 20 == 0, k == 40);

        random_base = words_queued;
        while (words_queued - random_base < 940)
            queue_random_phase();

        settle();
        repeat (10) @(posedge i_clk);
        if (placements_due.size() != 0)
            note_mismatch("results never returned, count", 0, placements_due.size());
        $display("covered %0d pixel words under %0d frame settings", words_taken,
                 settings_used);
        $display("saw %0d frame ends and %0d invalid-rotation words, %0d mismatches",
                 frames_closed, bad_seen, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("timeout with %0d results still due", placements_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
